[rtl/tdsk_pkg.sv]
// Shared types, constants and round functions for the TEA decryption core.
package tdsk_pkg;

    localparam int ROUNDS = 32;
    localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;

    // Two fixed 128-bit keys, word 0 first.
    localparam logic [31:0] KEY_TABLE [2][4] = '{
        '{32'h09f4fbbd, 32'h9681884a, 32'h352027e9, 32'hf3dee5a7},
        '{32'h7aa9648f, 32'h7fae6994, 32'hc0efaad5, 32'h42712c57}
    };

    typedef struct packed {
        logic [31:0] cipher_first;
        logic [31:0] cipher_second;
        logic        key_select;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] plain_first;
        logic [31:0] plain_second;
    } out_beat_t;

    // Block state as it travels down the round pipeline.
    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
        logic        key_select;
    } work_t;

    // Round sum for round r (counted from 0): DELTA times the rounds still to go.
    function automatic logic [31:0] round_sum(input int r);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(ROUNDS - r);
        return prod[31:0];
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] w, input logic [31:0] sum,
                                        input logic [31:0] ka, input logic [31:0] kb);
        return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
    endfunction

endpackage

[rtl/tea_decrypt_selectable_key_core.sv]
// Top level of the pipelined TEA decryption core with two selectable fixed keys.
//
// Usage:
//   The input channel (s_valid, s_ready, s_data) takes one 64-bit ciphertext
//   block per beat as two 32-bit words plus a key-select bit. The result
//   channel (m_valid, m_ready, m_data) returns the decrypted words, one beat
//   per input beat, in order.
//   An accepted input beat reaches m_valid through the round pipeline: each
//   round takes two register stages, one per half-round (one subtract of a
//   mixed word).
//   Throughput is one beat per cycle while m_ready is high.
//   Reset (aresetn low, synchronous) empties the pipeline; no beat is in
//   flight afterwards and m_valid is low.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_ready goes low in the same cycle; bubbles are filled when m_valid
//   is low, so no beat is dropped or repeated. The result payload holds
//   steady while m_valid waits for m_ready.
module tea_decrypt_selectable_key_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tdsk_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tdsk_pkg::out_beat_t m_data
);

    logic            advance;
    logic            stage_valid [tdsk_pkg::ROUNDS + 1];
    tdsk_pkg::work_t stage_work  [tdsk_pkg::ROUNDS + 1];

    assign advance = m_ready || !m_valid;
    assign s_ready = advance;

    assign stage_valid[0]           = s_valid;
    assign stage_work[0].first      = s_data.cipher_first;
    assign stage_work[0].second     = s_data.cipher_second;
    assign stage_work[0].key_select = s_data.key_select;

    for (genvar i = 0; i < tdsk_pkg::ROUNDS; i++) begin : g_round
        tdsk_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .sum       (tdsk_pkg::round_sum(i)),
            .in_valid  (stage_valid[i]),
            .in_work   (stage_work[i]),
            .out_valid (stage_valid[i + 1]),
            .out_work  (stage_work[i + 1])
        );
    end

    assign m_valid             = stage_valid[tdsk_pkg::ROUNDS];
    assign m_data.plain_first  = stage_work[tdsk_pkg::ROUNDS].first;
    assign m_data.plain_second = stage_work[tdsk_pkg::ROUNDS].second;

endmodule

[rtl/tdsk_round.sv]
// One decryption round split over two register stages, one half-round each.
module tdsk_round (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [31:0]          sum,
    input  logic                 in_valid,
    input  tdsk_pkg::work_t      in_work,
    output logic                 out_valid,
    output tdsk_pkg::work_t      out_work
);

    logic            mid_valid_reg;
    tdsk_pkg::work_t mid_work_reg;
    tdsk_pkg::work_t mid_work_next;
    logic            out_valid_reg;
    tdsk_pkg::work_t out_work_reg;
    tdsk_pkg::work_t out_work_next;

    // First half updates the second word with key words 2 and 3.
    always_comb begin
        mid_work_next        = in_work;
        mid_work_next.second = in_work.second - tdsk_pkg::mix(in_work.first, sum,
            tdsk_pkg::KEY_TABLE[in_work.key_select][2],
            tdsk_pkg::KEY_TABLE[in_work.key_select][3]);
    end

    // Second half updates the first word with key words 0 and 1.
    always_comb begin
        out_work_next       = mid_work_reg;
        out_work_next.first = mid_work_reg.first - tdsk_pkg::mix(mid_work_reg.second, sum,
            tdsk_pkg::KEY_TABLE[mid_work_reg.key_select][0],
            tdsk_pkg::KEY_TABLE[mid_work_reg.key_select][1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            mid_valid_reg <= in_valid;
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mid_work_reg <= mid_work_next;
            out_work_reg <= out_work_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_work  = out_work_reg;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the pipelined TEA decryption core with two fixed keys.
`timescale 1ns / 1ps

class tea_plain_scoreboard;
    tdsk_pkg::out_beat_t plain_q[$];
    int unsigned         error_count;

    function new();
        error_count = 0;
    endfunction

    // Key word 0 sits in the top 32 bits of each 128-bit key.
    function logic [31:0] key_word(input logic sel, input int idx);
        logic [127:0] key;
        key = sel ? 128'h7aa9648f_7fae6994_c0efaad5_42712c57
                  : 128'h09f4fbbd_9681884a_352027e9_f3dee5a7;
        return key[127 - 32 * idx -: 32];
    endfunction

    function logic [31:0] mix_word(input logic [31:0] w, input logic [31:0] sum,
                                   input logic [31:0] ka, input logic [31:0] kb);
        return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
    endfunction

    function tdsk_pkg::out_beat_t decrypt(input tdsk_pkg::in_beat_t c);
        logic [31:0]         first;
        logic [31:0]         second;
        logic [31:0]         sum;
        tdsk_pkg::out_beat_t p;
        first  = c.cipher_first;
        second = c.cipher_second;
        // The product wraps to 32 bits, which gives the usual starting sum.
        sum    = tdsk_pkg::TEA_DELTA * tdsk_pkg::ROUNDS;
        for (int r = 0; r < tdsk_pkg::ROUNDS; r++) begin
            second = second - mix_word(first, sum, key_word(c.key_select, 2),
                                       key_word(c.key_select, 3));
            first  = first - mix_word(second, sum, key_word(c.key_select, 0),
                                      key_word(c.key_select, 1));
            sum    = sum - tdsk_pkg::TEA_DELTA;
        end
        p.plain_first  = first;
        p.plain_second = second;
        return p;
    endfunction

    function void note_cipher(input tdsk_pkg::in_beat_t c);
        plain_q.push_back(decrypt(c));
    endfunction

    function void check_plain(input tdsk_pkg::out_beat_t got);
        tdsk_pkg::out_beat_t want;
        if (plain_q.size() == 0) begin
            if (error_count < 10) begin
                $display("unexpected result beat: first %h second %h",
                         got.plain_first, got.plain_second);
            end
            error_count++;
        end else begin
            want = plain_q.pop_front();
            if (got.plain_first !== want.plain_first ||
                got.plain_second !== want.plain_second) begin
                if (error_count < 10) begin
                    $display("mismatch: expected first %h second %h, got first %h second %h",
                             want.plain_first, want.plain_second,
                             got.plain_first, got.plain_second);
                end
                error_count++;
            end
        end
    endfunction

    function int pending();
        return plain_q.size();
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 264;
    localparam int QUIET_CYCLES    = 2 * tdsk_pkg::ROUNDS + 16;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    tdsk_pkg::in_beat_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    tdsk_pkg::out_beat_t m_data;

    int unsigned         cycle_count = 0;
    int unsigned         sender_idle = 37;
    int unsigned         receiver_idle = 57;
    tea_plain_scoreboard sb;

    tea_decrypt_selectable_key_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= receiver_idle);
        end else begin
            m_ready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_plain(m_data);
        end
    end

    function automatic tdsk_pkg::in_beat_t make_cipher(input logic [31:0] first,
                                                       input logic [31:0] second,
                                                       input logic sel);
        tdsk_pkg::in_beat_t c;
        c.cipher_first  = first;
        c.cipher_second = second;
        c.key_select    = sel;
        return c;
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        case ($urandom_range(15))
            0: w = 32'h0000_0000;
            1: w = 32'hffff_ffff;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Holds the beat until the core takes it; the gap before it is random.
    task automatic send_cipher(input tdsk_pkg::in_beat_t c);
        if ($urandom_range(99) < sender_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        sb.note_cipher(c);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [31:0] corner_first [8];
        logic [31:0] corner_second [8];
        corner_first  = '{32'h0, 32'hffffffff, 32'h0, 32'hffffffff,
                          32'h80000000, 32'h00000001, 32'haaaaaaaa, 32'hdeadbeef};
        corner_second = '{32'h0, 32'hffffffff, 32'hffffffff, 32'h0,
                          32'h00000001, 32'h80000000, 32'h55555555, 32'h01234567};
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int sel = 0; sel < 2; sel++) begin
            for (int i = 0; i < 8; i++) begin
                send_cipher(make_cipher(corner_first[i], corner_second[i], sel[0]));
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin sender_idle = 37; receiver_idle = 57; end
                1: begin sender_idle = 57; receiver_idle = 37; end
                default: begin sender_idle = 0; receiver_idle = 0; end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_cipher(make_cipher(random_word(), random_word(),
                                        1'($urandom_range(1))));
            end
            // Let the pipeline run empty before the idle pattern changes.
            drain_results();
        end

        repeat (QUIET_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.error_count++;
        end
        if (sb.error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
